/* rtl/gda_pkg.sv */
// Shared widths, command/status structs, state type and calendar tables for the date block.
package gda_pkg;

	localparam int YEAR_WIDTH  = 16;
	localparam int COUNT_WIDTH = 12;

	// stream packing
	localparam int IN_W        = 4 + 5 + YEAR_WIDTH + COUNT_WIDTH;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = 4 + 5 + YEAR_WIDTH + 9 + 9 + 1 + 4;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam int IN_MONTH_LO = 0;
	localparam int IN_DAY_LO   = 4;
	localparam int IN_YEAR_LO  = 9;
	localparam int IN_COUNT_LO = 9 + YEAR_WIDTH;

	// compare width for remaining count against room in month (room needs 5 bits)
	localparam int CMP_W  = (COUNT_WIDTH > 5) ? COUNT_WIDTH : 5;

	// year / 25 by reciprocal: q = (y * DIV25_MUL) >> DIV25_SHIFT, exact for any year
	localparam int DIV25_SHIFT  = YEAR_WIDTH + 5;
	localparam int DIV25_PROD_W = 2 * YEAR_WIDTH + 1;
	localparam logic [YEAR_WIDTH:0] DIV25_MUL =
		(YEAR_WIDTH + 1)'(((64'd1 << DIV25_SHIFT) + 64'd24) / 64'd25);

	localparam logic [YEAR_WIDTH-1:0] YEAR_DEFAULT = YEAR_WIDTH'(2000);
	localparam logic [YEAR_WIDTH-1:0] YEAR_MAX     = {YEAR_WIDTH{1'b1}};
	localparam logic [3:0]            MONTH_DEC    = 4'd12;
	localparam logic [4:0]            MOD25        = 5'd25;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_MOD,
		ST_LOAD_DAY,
		ST_ADVANCE,
		ST_FINISH
	} gda_state_t;

	typedef struct packed {
		logic take;      // latch the accepted beat
		logic mod_step;  // year mod 25: quotient, then remainder
		logic day_check; // validate loaded day
		logic adv_step;  // one month of advance
		logic publish;   // load the output register
	} gda_cmd_t;

	typedef struct packed {
		logic in_load;   // action bit of the offered beat is load
		logic mod_last;  // remainder cycle of the mod 25 pass
		logic adv_done;  // this advance step finishes the action
	} gda_status_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the months before m, common year
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

/* rtl/gregorian_date_advance.sv */
// Top level of the Gregorian date register with load and advance actions.
//
// Input stream (s_*): one beat is one action. s_tuser selects it: 0 loads the
// date in s_tdata after repair, 1 advances the held date by day_count days.
// Output stream (m_*): exactly one result beat per input beat, in order.
//
// Sequencing, one action at a time:
//   load    : year mod 25 by reciprocal multiply, quotient then remainder,
//             sets the leap status, then the day check.
//   advance : one step per month crossed; a zero count finishes at its first
//             step.
// The sequencer is back in idle in the cycle after the result is published,
// and only then can the next beat be accepted.
// s_tready is high only while the sequencer is idle; the next beat may be
// taken while a finished result still waits in the output register.
// A stalled receiver (m_tready low) holds m_tdata; a following action runs
// to completion and waits in its final state until the register frees.
// Reset (arst_n low) sets the date to 1 January 2000 and drops m_tvalid.
module gregorian_date_advance
	import gda_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [3:0] new_month, [8:4] new_day, [+YEAR_WIDTH] new_year, [+COUNT_WIDTH] day_count
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// [0] action
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [3:0] month_now, [8:4] day_now, [+YEAR_WIDTH] year_now, then day_of_year (9),
	// days_left (9), leap_flag, month_repaired, year_repaired, day_repaired, year_overflow
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	gda_cmd_t    cmd;
	gda_status_t status;

	gda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gda_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.status  (status),
		.m_tdata (m_tdata)
	);

	// result field views for the checks below
	localparam int OUT_DOY_LO  = 9 + YEAR_WIDTH;
	localparam int OUT_LEFT_LO = OUT_DOY_LO + 9;
	localparam int OUT_LEAP    = OUT_LEFT_LO + 9;
	localparam int OUT_OVF     = OUT_LEAP + 4;

	logic [3:0]            chk_month;
	logic [4:0]            chk_day;
	logic [YEAR_WIDTH-1:0] chk_year;
	logic [8:0]            chk_doy, chk_left;
	logic                  chk_leap;

	assign chk_month = m_tdata[3:0];
	assign chk_day   = m_tdata[8:4];
	assign chk_year  = m_tdata[9 +: YEAR_WIDTH];
	assign chk_doy   = m_tdata[OUT_DOY_LO +: 9];
	assign chk_left  = m_tdata[OUT_LEFT_LO +: 9];
	assign chk_leap  = m_tdata[OUT_LEAP];

	// a reported date is always a real calendar date
	a_valid_date: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (chk_day != 5'd0) && (chk_day <= month_len(chk_month, chk_leap)))
		else $error("result date out of range");

	// day of year and days left add up to the year length
	a_year_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (10'(chk_doy) + 10'(chk_left)) == (chk_leap ? 10'd366 : 10'd365))
		else $error("day_of_year and days_left disagree");

	// overflow only ever lands on the last day of the largest year
	a_ovf_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[OUT_OVF]) |->
			(chk_month == MONTH_DEC) && (chk_day == 5'd31) && (chk_year == YEAR_MAX))
		else $error("overflow away from the end of the largest year");

	// one action at a time: no second beat straight after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while an action is in flight");

endmodule

/* rtl/gda_ctrl.sv */
// Sequencer for load, advance and result hand-off.
module gda_ctrl
	import gda_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  gda_status_t status,
	output gda_cmd_t    cmd
);

	gda_state_t state_q, state_d;
	logic       m_tvalid_q;
	logic       accept;
	logic       can_publish;

	assign accept      = s_tvalid && s_tready;
	assign can_publish = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = status.in_load ? ST_LOAD_MOD : ST_ADVANCE;
			end
			ST_LOAD_MOD: begin
				if (status.mod_last) state_d = ST_LOAD_DAY;
			end
			ST_LOAD_DAY: state_d = ST_FINISH;
			ST_ADVANCE: begin
				if (status.adv_done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (can_publish) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		cmd           = '0;
		cmd.take      = accept;
		cmd.mod_step  = (state_q == ST_LOAD_MOD);
		cmd.day_check = (state_q == ST_LOAD_DAY);
		cmd.adv_step  = (state_q == ST_ADVANCE);
		cmd.publish   = (state_q == ST_FINISH) && can_publish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish)   m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

/* rtl/gda_dp.sv */
// Date registers, mod 25 unit, month stepper and result register.
module gda_dp
	import gda_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  gda_cmd_t               cmd,
	output gda_status_t            status,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [3:0]            month_q;
	logic [4:0]            day_q;
	logic [YEAR_WIDTH-1:0] year_q;
	logic [4:0]            mod_q;    // year_q mod 25
	logic [YEAR_WIDTH-1:0] yload_q;
	logic [4:0]            quo_q;    // low bits of yload_q / 25
	logic                  phase_q;
	logic [4:0]            nd_q;
	logic [COUNT_WIDTH-1:0] rem_q;
	logic                  mfix_q, yfix_q, dfix_q, ovf_q;
	logic [OUT_TDATA_W-1:0] out_q;

	logic [3:0]            in_month;
	logic [4:0]            in_day;
	logic [YEAR_WIDTH-1:0] in_year;
	logic [COUNT_WIDTH-1:0] in_count;
	logic                  in_month_ok;

	logic                  leap;
	logic [4:0]            len;
	logic [4:0]            room;
	logic [CMP_W-1:0]      rem_ext, room_ext, rem_next;
	logic                  fits;
	logic                  at_end;
	logic [DIV25_PROD_W-1:0] prod;
	logic [4:0]            quo25;
	logic [4:0]            mod_n;
	logic [8:0]            doy, total;

	assign in_month = s_tdata[IN_MONTH_LO +: 4];
	assign in_day   = s_tdata[IN_DAY_LO +: 5];
	assign in_year  = s_tdata[IN_YEAR_LO +: YEAR_WIDTH];
	assign in_count = s_tdata[IN_COUNT_LO +: COUNT_WIDTH];
	assign in_month_ok = (in_month >= 4'd1) && (in_month <= MONTH_DEC);

	// divisible by 4, except by 100 unless by 400
	assign leap = (year_q[1:0] == 2'b00) && ((mod_q != 5'd0) || (year_q[3:0] == 4'd0));
	assign len  = month_len(month_q, leap);
	assign room = len - day_q;

	assign rem_ext  = CMP_W'(rem_q);
	assign room_ext = CMP_W'(room);
	assign fits     = rem_ext <= room_ext;
	assign rem_next = rem_ext - room_ext - CMP_W'(1);
	assign at_end   = (month_q == MONTH_DEC) && (year_q == YEAR_MAX);

	// quotient by reciprocal; remainder < 32, so five low bits of y - 25q suffice
	assign prod  = DIV25_PROD_W'(yload_q) * DIV25_PROD_W'(DIV25_MUL);
	assign quo25 = quo_q * MOD25;
	assign mod_n = yload_q[4:0] - quo25;

	assign doy   = days_before(month_q) + 9'(leap && (month_q > 4'd2)) + 9'(day_q);
	assign total = leap ? 9'd366 : 9'd365;

	always_comb begin
		status          = '0;
		status.in_load  = !s_tuser;
		status.mod_last = phase_q;
		status.adv_done = fits || at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			month_q <= 4'd1;
			day_q   <= 5'd1;
			year_q  <= YEAR_DEFAULT;
			mod_q   <= 5'd0;
		end else begin
			if (cmd.take && !s_tuser) begin
				month_q <= in_month_ok ? in_month : 4'd1;
				year_q  <= (in_year != '0) ? in_year : YEAR_DEFAULT;
				mod_q   <= 5'd0;
			end
			if (cmd.mod_step && phase_q) mod_q <= mod_n;
			if (cmd.day_check) begin
				if ((nd_q >= 5'd1) && (nd_q <= len)) day_q <= nd_q;
				else                                  day_q <= 5'd1;
			end
			if (cmd.adv_step) begin
				if (fits) begin
					day_q <= day_q + rem_ext[4:0];
				end else if (month_q != MONTH_DEC) begin
					month_q <= month_q + 4'd1;
					day_q   <= 5'd1;
				end else if (year_q != YEAR_MAX) begin
					year_q  <= year_q + YEAR_WIDTH'(1);
					month_q <= 4'd1;
					day_q   <= 5'd1;
					mod_q   <= (mod_q == 5'd24) ? 5'd0 : mod_q + 5'd1;
				end else begin
					day_q <= len;
				end
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mfix_q  <= !s_tuser && !in_month_ok;
			yfix_q  <= !s_tuser && (in_year == '0);
			dfix_q  <= 1'b0;
			ovf_q   <= 1'b0;
			nd_q    <= in_day;
			rem_q   <= in_count;
			yload_q <= (in_year != '0) ? in_year : YEAR_DEFAULT;
			phase_q <= 1'b0;
		end
		if (cmd.mod_step) begin
			quo_q   <= prod[DIV25_SHIFT +: 5];
			phase_q <= 1'b1;
		end
		if (cmd.day_check) dfix_q <= !((nd_q >= 5'd1) && (nd_q <= len));
		if (cmd.adv_step && !fits) begin
			rem_q <= rem_next[COUNT_WIDTH-1:0];
			if (at_end) ovf_q <= 1'b1;
		end
		if (cmd.publish) begin
			out_q <= OUT_TDATA_W'({ovf_q, dfix_q, yfix_q, mfix_q, leap,
				total - doy, doy, year_q, day_q, month_q});
		end
	end

	assign m_tdata = out_q;

endmodule
